>>> hw/rtl/cnfsa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the slot allocator.
package cnfsa_pkg;

   localparam int MaxSlotsDflt = 1024;
   localparam int CountRstDflt = 1024;
   localparam int SlotW        = 11;
   localparam int WordW        = 32;
   localparam int ColW         = $clog2(WordW);
   localparam int WideW        = 18;

   localparam int ReqDataW = 16;
   localparam int ReqUserW = 1;
   localparam int RspDataW = 16;
   localparam int RspUserW = 2;
   localparam int CsrDataW = 16;

   localparam logic FuncTake    = 1'b0;
   localparam logic FuncRelease = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_WAS_FREE = 2'd2,
      ST_BAD      = 2'd3
   } cnfsa_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FIND,
      S_EVAL,
      S_DONE
   } cnfsa_state_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic set_bad;
      logic read_slot;
      logic start_take;
      logic read_cand;
      logic wrap;
      logic set_full;
      logic eval;
      logic load_rsp;
   } cnfsa_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic bad;
      logic release_req;
      logic cand_found;
      logic phase;
      logic hit;
      logic rsp_free;
   } cnfsa_stat_type;

endpackage

>>> hw/rtl/cnfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnfsa_ram #(
   parameter int Width = 32,
   parameter int Depth = 32,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cnfsa_ctrl.sv
// Controller state machine sequencing clear, search, update and response.
module cnfsa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  cnfsa_pkg::cnfsa_stat_type stat,
   output cnfsa_pkg::cnfsa_cmd_type  cmd
);
   import cnfsa_pkg::*;

   cnfsa_state_type state_ff;
   cnfsa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (stat.bad) begin
               cmd.set_bad = 1'b1;
               state_in    = S_DONE;
            end else if (stat.release_req) begin
               cmd.read_slot = 1'b1;
               state_in      = S_EVAL;
            end else begin
               cmd.start_take = 1'b1;
               state_in       = S_FIND;
            end
         end
         S_FIND: begin
            priority if (stat.cand_found) begin
               cmd.read_cand = 1'b1;
               state_in      = S_EVAL;
            end else if (!stat.phase) begin
               cmd.wrap = 1'b1;
            end else begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.release_req || stat.hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FIND;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ($past(state_ff) == S_FIND || $past(state_ff) == S_CHECK))
      else $error("row evaluated without a preceding read");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (state_ff == S_CHECK) && !req_tready)
      else $error("request accepted while busy");
`endif

endmodule

>>> hw/rtl/cnfsa_dp.sv
// Datapath: slot count, row memory, free-row summary, search and result registers.
module cnfsa_dp #(
   parameter int MAX_SLOTS = cnfsa_pkg::MaxSlotsDflt
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic [cnfsa_pkg::ReqDataW-1:0]       req_tdata,
   input  logic [cnfsa_pkg::ReqUserW-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cnfsa_pkg::RspDataW-1:0]       rsp_tdata,
   output logic [cnfsa_pkg::RspUserW-1:0]       rsp_tuser,
   input  logic                                 csr_tvalid,
   output logic                                 csr_tready,
   input  logic [cnfsa_pkg::CsrDataW-1:0]       csr_tdata,
   input  cnfsa_pkg::cnfsa_cmd_type             cmd,
   output cnfsa_pkg::cnfsa_stat_type            stat
);
   import cnfsa_pkg::*;

   localparam int Rows     = (MAX_SLOTS + WordW - 1) / WordW;
   localparam int RowW     = (Rows > 1) ? $clog2(Rows) : 1;
   localparam int IdxW     = RowW + ColW;
   localparam int LoW      = IdxW + 1;
   localparam int CountRst = (MAX_SLOTS < CountRstDflt) ? MAX_SLOTS : CountRstDflt;

   logic [SlotW-1:0]       count_ff;
   logic [SlotW-1:0]       count_in;
   logic [SlotW-1:0]       cfg_val;
   logic                   func_ff;
   logic                   bad_ff;
   logic [IdxW-1:0]        idx_ff;
   logic [LoW-1:0]         lo_ff;
   logic                   phase_ff;
   logic [RowW-1:0]        row_ff;
   logic [RowW-1:0]        clr_cnt_ff;
   logic [Rows-1:0]        sum_ff;
   cnfsa_status_type       res_status_ff;
   logic [SlotW-1:0]       res_grant_ff;
   logic                   rsp_valid_ff;
   cnfsa_status_type       rsp_status_ff;
   logic [SlotW-1:0]       rsp_grant_ff;

   logic [SlotW-1:0]       req_slot;
   logic                   req_bad;
   logic [WideW-1:0]       slot_wide;
   logic [WideW-1:0]       lim_wide;
   logic [IdxW-1:0]        lim;
   logic [RowW:0]          row_lo;
   logic [RowW:0]          row_lim;
   logic                   cand_found;
   logic [RowW-1:0]        cand_row;
   logic [ColW-1:0]        col_lo;
   logic [ColW-1:0]        col_lim;
   logic [ColW-1:0]        col_slot;
   logic                   at_lo;
   logic                   at_lim;
   logic                   hit;
   logic [ColW-1:0]        hit_col;
   logic                   slot_bit;
   logic [WideW-1:0]       grant_wide;

   logic                   rd_en;
   logic [RowW-1:0]        rd_addr;
   logic [WordW-1:0]       rd_data;
   logic                   wr_en;
   logic [RowW-1:0]        wr_addr;
   logic [WordW-1:0]       wr_data;

   assign csr_tready = 1'b1;
   assign req_slot   = req_tdata[SlotW-1:0];
   assign req_bad    = (req_slot == '0) || (req_slot > count_ff);
   assign slot_wide  = WideW'(req_slot) - WideW'(1);
   assign lim_wide   = WideW'(count_ff) - WideW'(1);
   assign lim        = lim_wide[IdxW-1:0];
   assign row_lo     = lo_ff[LoW-1:ColW];
   assign row_lim    = {1'b0, lim[IdxW-1:ColW]};
   assign col_lo     = lo_ff[ColW-1:0];
   assign col_lim    = lim[ColW-1:0];
   assign col_slot   = idx_ff[ColW-1:0];
   assign at_lo      = ({1'b0, row_ff} == row_lo);
   assign at_lim     = ({1'b0, row_ff} == row_lim);
   assign slot_bit   = rd_data[col_slot];
   assign grant_wide = WideW'({row_ff, hit_col}) + WideW'(1);

   always_comb begin
      cfg_val  = csr_tdata[SlotW-1:0];
      count_in = cfg_val;
      priority if (cfg_val == '0) begin
         count_in = SlotW'(1);
      end else if (WideW'(cfg_val) > WideW'(MAX_SLOTS)) begin
         count_in = SlotW'(MAX_SLOTS);
      end else begin
         count_in = cfg_val;
      end
   end

   always_comb begin
      cand_found = 1'b0;
      cand_row   = '0;
      for (int r = Rows - 1; r >= 0; r--) begin
         if (sum_ff[r] && ((RowW+1)'(r) >= row_lo) && ((RowW+1)'(r) <= row_lim)) begin
            cand_found = 1'b1;
            cand_row   = RowW'(r);
         end
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_col = '0;
      for (int b = WordW - 1; b >= 0; b--) begin
         if (rd_data[b] && (!at_lo || ColW'(b) >= col_lo) &&
             (!at_lim || ColW'(b) <= col_lim)) begin
            hit     = 1'b1;
            hit_col = ColW'(b);
         end
      end
   end

   always_comb begin
      rd_en   = cmd.read_cand || cmd.read_slot;
      rd_addr = cmd.read_cand ? cand_row : idx_ff[IdxW-1:ColW];
      wr_addr = cmd.clear ? clr_cnt_ff : row_ff;
      wr_en   = 1'b0;
      wr_data = '1;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.eval) begin
         if (func_ff == FuncRelease) begin
            wr_en   = !slot_bit;
            wr_data = rd_data | (WordW'(1) << col_slot);
         end else begin
            wr_en   = hit;
            wr_data = rd_data & ~(WordW'(1) << hit_col);
         end
      end
   end

   cnfsa_ram #(
      .Width (WordW),
      .Depth (Rows),
      .AddrW (RowW)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= SlotW'(CountRst);
         clr_cnt_ff   <= '0;
         sum_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         if (csr_tvalid && csr_tready) begin
            count_ff <= count_in;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + RowW'(1);
         end
         if (wr_en && cmd.eval) begin
            sum_ff[row_ff] <= |wr_data;
         end
         if (cmd.start_take) begin
            phase_ff <= 1'b0;
         end else if (cmd.wrap) begin
            phase_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req && req_tvalid) begin
         func_ff <= req_tuser[0];
         bad_ff  <= req_bad;
         idx_ff  <= slot_wide[IdxW-1:0];
      end
      if (rd_en) begin
         row_ff <= rd_addr;
      end
      if (cmd.start_take) begin
         lo_ff <= {1'b0, idx_ff};
      end else if (cmd.wrap) begin
         lo_ff <= '0;
      end else if (cmd.eval) begin
         lo_ff <= LoW'({row_ff, {ColW{1'b0}}}) + LoW'(WordW);
      end
      if (cmd.set_bad) begin
         res_status_ff <= ST_BAD;
         res_grant_ff  <= '0;
      end else if (cmd.set_full) begin
         res_status_ff <= ST_FULL;
         res_grant_ff  <= '0;
      end else if (cmd.eval) begin
         res_grant_ff <= '0;
         if (func_ff == FuncRelease) begin
            res_status_ff <= slot_bit ? ST_WAS_FREE : ST_OK;
         end else if (hit) begin
            res_status_ff <= ST_OK;
            res_grant_ff  <= grant_wide[SlotW-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_grant_ff  <= res_grant_ff;
      end
   end

   assign stat.clr_last    = (clr_cnt_ff == RowW'(Rows - 1));
   assign stat.bad         = bad_ff;
   assign stat.release_req = (func_ff == FuncRelease);
   assign stat.cand_found  = cand_found;
   assign stat.phase       = phase_ff;
   assign stat.hit         = hit;
   assign stat.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - SlotW){1'b0}}, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && res_status_ff == ST_OK && func_ff == FuncTake)
      |-> (res_grant_ff != '0) && (res_grant_ff <= count_ff))
      else $error("granted slot outside the configured range");

   a_summary_tracks_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && wr_en) |=> (sum_ff[$past(row_ff)] == $past(|wr_data)))
      else $error("free-row summary out of step with row write");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response overwritten");
`endif

endmodule

>>> hw/rtl/circular_next_free_slot_allocator_top.sv
// Top level of the circular next-free slot allocator.
//
// Request channel (req_): one beat per request. req_tuser is the kind (take or
// release), req_tdata holds the slot number. A take grants the first free slot at
// or above the named one, else wraps to the lowest free slot, else answers full.
// A release frees a taken slot or answers that it was already free.
// Response channel (rsp_): one beat per request, in request order; rsp_tuser is the
// status, rsp_tdata the granted slot (zero unless a take succeeds).
// Config channel (csr_): writes the active slot count; write only while idle.
// A bad slot number is answered straight after the check, a release after one read and
// evaluate of its slot's row, and a take after searching one candidate row of 32 slots
// per read/evaluate pair on the row memory; a new request is taken only when idle.
// Reset: all slots free; a clearing pass writes every row of the row memory, during
// which req_tready stays low.
// A stalled response holds in its output register; the next request is accepted
// meanwhile and its result waits until that register frees.
module circular_next_free_slot_allocator_top #(
   parameter int MAX_SLOTS = cnfsa_pkg::MaxSlotsDflt
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cnfsa_pkg::ReqDataW-1:0] req_tdata,  // [10:0] slot
   input  logic [cnfsa_pkg::ReqUserW-1:0] req_tuser,  // [0] func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cnfsa_pkg::RspDataW-1:0] rsp_tdata,  // [10:0] granted_slot
   output logic [cnfsa_pkg::RspUserW-1:0] rsp_tuser,  // [1:0] status
   input  logic                           csr_tvalid,
   output logic                           csr_tready,
   input  logic [cnfsa_pkg::CsrDataW-1:0] csr_tdata   // [10:0] slot_count
);
   import cnfsa_pkg::*;

   cnfsa_cmd_type  cmd;
   cnfsa_stat_type stat;

   cnfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cnfsa_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

>>> sim/circular_next_free_slot_allocator_top_test.sv
// Testbench for the circular next-free slot allocator: directed and random take/release traffic.
module circular_next_free_slot_allocator_top_test;
   import cnfsa_pkg::*;

   localparam int MaxSlots   = MaxSlotsDflt;
   localparam int StuckLimit = 4000;

   typedef struct packed {
      cnfsa_status_type status;
      logic [SlotW-1:0] slot;
   } slot_outcome_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;   // [10:0] slot
   logic [ReqUserW-1:0] req_tuser  = '0;   // [0] func
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;         // [10:0] granted_slot
   logic [RspUserW-1:0] rsp_tuser;         // [1:0] status
   logic                csr_tvalid = 1'b0;
   logic                csr_tready;
   logic [CsrDataW-1:0] csr_tdata  = '0;   // [10:0] slot_count

   bit               slot_free [1:MaxSlots];
   int               slot_limit = CountRstDflt;
   slot_outcome_type pending_grants [$];
   int               mismatches = 0;
   int               stuck_cycles = 0;
   bit               quiet_stretch = 1'b0;

   circular_next_free_slot_allocator_top #(
      .MAX_SLOTS(MaxSlots)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic slot_outcome_type allocate_or_free(input logic func,
                                                         input logic [SlotW-1:0] slot);
      slot_outcome_type outcome;
      int               grant;
      outcome.status = ST_OK;
      outcome.slot   = '0;
      grant          = 0;
      if (slot == 0 || slot > slot_limit) begin
         outcome.status = ST_BAD;
      end else if (func == FuncTake) begin
         for (int s = slot; s <= slot_limit && grant == 0; s++)
            if (slot_free[s]) grant = s;
         for (int s = 1; s <= slot_limit && grant == 0; s++)
            if (slot_free[s]) grant = s;
         if (grant == 0) begin
            outcome.status = ST_FULL;
         end else begin
            slot_free[grant] = 1'b0;
            outcome.slot     = SlotW'(grant);
         end
      end else if (slot_free[slot]) begin
         outcome.status = ST_WAS_FREE;
      end else begin
         slot_free[slot] = 1'b1;
      end
      return outcome;
   endfunction

   task automatic send_request(input logic func, input logic [SlotW-1:0] slot);
      slot_outcome_type outcome;
      while (!quiet_stretch && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'(slot);
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      outcome        = allocate_or_free(func, slot);
      pending_grants = {pending_grants, outcome};
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [SlotW-1:0] value);
      drain_responses();
      csr_tvalid <= 1'b1;
      csr_tdata  <= CsrDataW'(value);
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      if (value == 0)
         slot_limit = 1;
      else if (value > MaxSlots)
         slot_limit = MaxSlots;
      else
         slot_limit = value;
   endtask

   task automatic test_reset_count();
      send_request(FuncTake, 11'd0);
      send_request(FuncTake, 11'd2047);
      send_request(FuncTake, 11'd1025);
      send_request(FuncTake, 11'd1024);
      send_request(FuncTake, 11'd1024);
      send_request(FuncRelease, 11'd1024);
      send_request(FuncRelease, 11'd1024);
      send_request(FuncRelease, 11'd0);
      send_request(FuncRelease, 11'd2047);
      send_request(FuncTake, 11'd1);
   endtask

   task automatic test_count_extremes();
      write_slot_count(11'd0);
      send_request(FuncTake, 11'd1);
      send_request(FuncRelease, 11'd1);
      send_request(FuncTake, 11'd1);
      send_request(FuncTake, 11'd2);
      send_request(FuncRelease, 11'd1);
      write_slot_count(11'd2047);
      send_request(FuncTake, 11'd1024);
      write_slot_count(11'd3);
      send_request(FuncTake, 11'd3);
      send_request(FuncTake, 11'd3);
      send_request(FuncTake, 11'd2);
      send_request(FuncTake, 11'd1);
      send_request(FuncRelease, 11'd2);
      send_request(FuncRelease, 11'd1024);
   endtask

   task automatic test_random_traffic();
      logic [SlotW-1:0] raw_count;
      logic [SlotW-1:0] slot;
      logic             func;
      int               take_pct;
      int               roll;
      int               start;
      int               idx;
      bit               found;
      for (int phase = 0; phase < 8; phase++) begin
         unique case (phase)
            0: raw_count = 11'd1024;
            1: raw_count = 11'd0;
            2: raw_count = 11'($urandom_range(2, 8));
            3: raw_count = 11'd2047;
            4: raw_count = 11'($urandom_range(9, 64));
            5: raw_count = 11'($urandom_range(1025, 2047));
            6: raw_count = 11'($urandom_range(1, 1024));
            default: raw_count = 11'($urandom_range(2, 24));
         endcase
         write_slot_count(raw_count);
         quiet_stretch = (phase == 3);
         take_pct = $urandom_range(35, 80);
         for (int n = 0; n < 100; n++) begin
            func = ($urandom_range(0, 99) < take_pct) ? FuncTake : FuncRelease;
            roll = $urandom_range(0, 99);
            if (roll < 5)
               slot = '0;
            else if (roll < 10)
               slot = 11'($urandom_range(0, 2047));
            else if (roll < 15)
               slot = 11'($urandom_range(slot_limit + 1, 2047));
            else
               slot = 11'($urandom_range(1, slot_limit));
            if (func == FuncRelease && roll >= 40) begin
               start = $urandom_range(1, slot_limit);
               found = 1'b0;
               for (int k = 0; k < slot_limit && !found; k++) begin
                  idx = (start - 1 + k) % slot_limit + 1;
                  if (!slot_free[idx]) begin
                     slot  = SlotW'(idx);
                     found = 1'b1;
                  end
               end
            end
            send_request(func, slot);
         end
      end
      quiet_stretch = 1'b0;
   endtask

   always @(posedge clock) begin
      slot_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: status %0d slot %0d", rsp_tuser, rsp_tdata);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata !== RspDataW'(want.slot)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected status %s slot %0d, %s %0d slot %0d",
                           want.status.name(), want.slot, "got status", rsp_tuser,
                           rsp_tdata);
            end
         end
      end
      rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= 22);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("Timeout: no beat accepted in %0d cycles", StuckLimit);
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      foreach (slot_free[i]) slot_free[i] = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_count();
      test_count_extremes();
      test_random_traffic();
      drain_responses();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
